FILE: sv/nbc_pkg.sv
`timescale 1ns / 1ps
package nbc_pkg;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_END,
    OP_PULL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } q_item_t;

  typedef enum logic [1:0] {
    KIND_POS,
    KIND_NEG,
    KIND_HEX
  } kind_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_PREP,
    ST_CONV
  } st_t;

  typedef enum logic [1:0] {
    SEC_BIN,
    SEC_DEC,
    SEC_HEX,
    SEC_SWAP
  } sec_t;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_NL        = 8'h0a;
  localparam logic [7:0] CH_MINUS     = 8'h2d;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] DIGIT_OFS    = 8'd48;
  localparam logic [7:0] ALPHA_OFS    = 8'd87;
  localparam logic [3:0] MAX_DEC_NIB  = 4'd9;

endpackage

FILE: sv/nbc_front.sv
`timescale 1ns / 1ps
module nbc_front import nbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] char_in,
  output q_item_t    q_item,
  output logic       q_valid,
  input  logic       q_pop
);

  // two-entry queue towards the back end
  q_item_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  q_item_t    cls;
  logic       push;

  always_comb begin
    cls.ch = char_in;
    if (action) begin
      cls.op = OP_PULL;
    end else if (char_in == CH_NL || char_in == CH_NUL) begin
      cls.op = OP_END;
    end else begin
      cls.op = OP_CHAR;
    end
  end

  assign in_stall = count[1];
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

FILE: sv/nbc_back.sv
`timescale 1ns / 1ps
module nbc_back import nbc_pkg::*; #(
  parameter int WORD_BITS       = 32,
  parameter int MAX_INPUT_CHARS = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  q_item_t    q_item,
  input  logic       q_valid,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] char_out,
  output logic       last_char,
  output logic       empty_res
);

  localparam int NB     = (WORD_BITS + 7) / 8;
  localparam int NIB    = (WORD_BITS + 3) / 4;
  localparam int DEC    = (WORD_BITS * 30103) / 100000 + 1;
  localparam int BCD_W  = 4 * DEC;
  localparam int POS_W  = $clog2(WORD_BITS + 4);
  localparam int EW     = POS_W + 1;
  localparam int NBW    = $clog2(WORD_BITS + 1);
  localparam int BIT_IW = $clog2(WORD_BITS);
  localparam int NIB_IW = $clog2(NIB);
  localparam int DIG_IW = $clog2(DEC);
  localparam int NDW    = $clog2(DEC + 1);
  localparam int CNT_W  = $clog2(MAX_INPUT_CHARS + 1);
  localparam int CONV_W = $clog2(WORD_BITS);

  st_t                  state;
  st_t                  state_next;
  logic [WORD_BITS-1:0] acc;
  kind_t                kind;
  logic [CNT_W-1:0]     chars_seen;
  logic                 pending;
  sec_t                 section;
  logic [POS_W-1:0]     pos;
  logic [NBW-1:0]       nb;
  logic [CONV_W-1:0]    conv_cnt;
  logic [WORD_BITS-1:0] v_sh;
  logic [WORD_BITS-1:0] m_sh;
  logic [WORD_BITS-1:0] s_sh;
  logic [BCD_W-1:0]     bcd_m;
  logic [BCD_W-1:0]     bcd_s;

  logic                 conv_last;
  logic                 out_free;
  logic [WORD_BITS-1:0] acc_mul;
  logic [WORD_BITS-1:0] digit;
  logic [WORD_BITS-1:0] mag;
  logic [WORD_BITS-1:0] swp;
  logic [NB*8-1:0]      swp_ext;
  logic [NB*8-1:0]      acc_bytes;
  logic [NIB*4-1:0]     acc_nib;
  logic [7:0]           nxt_ch;
  logic                 nxt_nl;
  logic [EW-1:0]        pe;
  logic [EW-1:0]        nbe;
  logic [EW-1:0]        nne;
  logic [EW-1:0]        bidx;
  logic [EW-1:0]        hidx;
  logic [3:0]           nib;

  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b, input logic din);
    logic [BCD_W-1:0] adj;
    adj = b;
    for (int i = 0; i < DEC; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], din};
  endfunction

  function automatic logic [NDW-1:0] ndig(input logic [BCD_W-1:0] b);
    logic [NDW-1:0] n;
    n = NDW'(1);
    for (int i = 1; i < DEC; i++) begin
      if (b[4*i +: 4] != 4'd0) begin
        n = NDW'(i + 1);
      end
    end
    return n;
  endfunction

  function automatic logic [7:0] dec_char(input logic [BCD_W-1:0] b, input logic neg,
                                          input logic [POS_W-1:0] p);
    logic [EW-1:0] nd;
    logic [EW-1:0] q;
    logic [EW-1:0] idx;
    logic [7:0]    ch;
    nd  = EW'(ndig(b));
    q   = EW'(p) - EW'(neg);
    idx = nd - EW'(1) - q;
    if (neg && p == '0) begin
      ch = CH_MINUS;
    end else if (q < nd) begin
      ch = CH_ZERO | {4'h0, b[{idx[DIG_IW-1:0], 2'b00} +: 4]};
    end else begin
      ch = CH_NL;
    end
    return ch;
  endfunction

  // line accumulate and conversion operands
  always_comb begin
    if (kind == KIND_HEX) begin
      acc_mul = acc << 4;
    end else begin
      acc_mul = (acc << 3) + (acc << 1);
    end
    if (q_item.ch < CH_LOWER_A) begin
      digit = WORD_BITS'(q_item.ch) - WORD_BITS'(DIGIT_OFS);
    end else begin
      digit = WORD_BITS'(q_item.ch) - WORD_BITS'(ALPHA_OFS);
    end
    mag = acc[WORD_BITS-1] ? (~acc + WORD_BITS'(1)) : acc;
    acc_bytes = (NB*8)'(acc);
    for (int i = 0; i < NB; i++) begin
      swp_ext[8*(NB-1-i) +: 8] = acc_bytes[8*i +: 8];
    end
    swp = swp_ext[WORD_BITS-1:0];
  end

  // next output character
  always_comb begin
    pe      = EW'(pos);
    nbe     = (nb == '0) ? EW'(1) : EW'(nb);
    nne     = (nbe + EW'(3)) >> 2;
    bidx    = nbe + EW'(1) - pe;
    hidx    = nne + EW'(1) - pe;
    acc_nib = (NIB*4)'(acc);
    nib     = acc_nib[{hidx[NIB_IW-1:0], 2'b00} +: 4];
    case (section)
      SEC_BIN: begin
        if (pos == '0) begin
          nxt_ch = CH_ZERO;
        end else if (pos == POS_W'(1)) begin
          nxt_ch = CH_B;
        end else if (pe < nbe + EW'(2)) begin
          nxt_ch = CH_ZERO | {7'h0, acc[bidx[BIT_IW-1:0]]};
        end else begin
          nxt_ch = CH_NL;
        end
      end
      SEC_DEC: nxt_ch = dec_char(bcd_m, acc[WORD_BITS-1], pos);
      SEC_HEX: begin
        if (pos == '0) begin
          nxt_ch = CH_ZERO;
        end else if (pos == POS_W'(1)) begin
          nxt_ch = CH_X;
        end else if (pe < nne + EW'(2)) begin
          nxt_ch = (nib <= MAX_DEC_NIB) ? (CH_ZERO + {4'h0, nib}) : ({4'h0, nib} + ALPHA_OFS);
        end else begin
          nxt_ch = CH_NL;
        end
      end
      default: nxt_ch = dec_char(bcd_s, 1'b0, pos);
    endcase
    nxt_nl = (nxt_ch == CH_NL);
  end

  assign conv_last = (conv_cnt == CONV_W'(WORD_BITS - 1));
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (q_pop && q_item.op == OP_END && !pending) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: state_next = ST_CONV;
      ST_CONV: begin
        if (conv_last) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_comb begin
    unique case (state)
      ST_RUN:  q_pop = q_valid && (q_item.op != OP_PULL || out_free);
      default: q_pop = 1'b0;
    endcase
  end

  // control and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      acc        <= '0;
      kind       <= KIND_POS;
      chars_seen <= '0;
      pending    <= 1'b0;
      section    <= SEC_BIN;
      pos        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop && q_item.op == OP_PULL) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_CONV && conv_last) begin
        pending <= 1'b1;
        section <= SEC_BIN;
        pos     <= '0;
      end
      if (q_pop) begin
        unique case (q_item.op)
          OP_CHAR: begin
            if (!pending && chars_seen < CNT_W'(MAX_INPUT_CHARS)) begin
              if (chars_seen == '0 && q_item.ch == CH_MINUS) begin
                kind <= KIND_NEG;
              end else if (chars_seen == CNT_W'(1) && q_item.ch == CH_X) begin
                kind <= KIND_HEX;
                acc  <= '0;
              end else begin
                acc <= acc_mul + digit;
              end
              chars_seen <= chars_seen + CNT_W'(1);
            end
          end
          OP_END: begin
            if (!pending && kind == KIND_NEG) begin
              acc <= '0 - acc;
            end
          end
          OP_PULL: begin
            if (pending) begin
              if (nxt_nl) begin
                pos <= '0;
                if (section == SEC_SWAP) begin
                  pending    <= 1'b0;
                  section    <= SEC_BIN;
                  acc        <= '0;
                  kind       <= KIND_POS;
                  chars_seen <= '0;
                end else begin
                  section <= sec_t'(section + 2'd1);
                end
              end else begin
                pos <= pos + POS_W'(1);
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // conversion datapath and output beat
  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      v_sh     <= acc;
      m_sh     <= mag;
      s_sh     <= swp;
      bcd_m    <= '0;
      bcd_s    <= '0;
      nb       <= '0;
      conv_cnt <= '0;
    end else if (state == ST_CONV) begin
      bcd_m    <= dabble(bcd_m, m_sh[WORD_BITS-1]);
      bcd_s    <= dabble(bcd_s, s_sh[WORD_BITS-1]);
      m_sh     <= m_sh << 1;
      s_sh     <= s_sh << 1;
      v_sh     <= v_sh << 1;
      conv_cnt <= conv_cnt + CONV_W'(1);
      if (nb == '0 && v_sh[WORD_BITS-1]) begin
        nb <= NBW'(WORD_BITS) - NBW'(conv_cnt);
      end
    end
    if (q_pop && q_item.op == OP_PULL) begin
      if (pending) begin
        char_out  <= nxt_ch;
        last_char <= nxt_nl && section == SEC_SWAP;
        empty_res <= 1'b0;
      end else begin
        char_out  <= CH_NUL;
        last_char <= 1'b0;
        empty_res <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_run: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == ST_RUN)
    else $error("queue popped during conversion");
  a_prep_conv: assert property (@(posedge clk) disable iff (rst)
    state == ST_PREP |=> state == ST_CONV)
    else $error("prep not followed by conversion");
  a_conv_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV && conv_last) |=> pending && section == SEC_BIN && pos == '0)
    else $error("conversion end did not arm readout");
  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    state != ST_RUN |-> !pending)
    else $error("readout pending while converting");
  a_last_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_char) |-> !empty_res && char_out == CH_NL)
    else $error("last beat malformed");
`endif

endmodule

FILE: sv/number_base_text_converter.sv
`timescale 1ns / 1ps
// channel | valid / stall       | beat fields
// --------+---------------------+------------------------------------
// in      | in_valid / in_stall | action, char_in
// out     | out_valid/out_stall | char_out, last_char, empty_res
//
// A line end starts a bit-serial double-dabble pass over the word (two units in
// parallel), during which the back end takes no items.
// A two-beat queue between front and back absorbs items during that pass.
// Synchronous reset clears line state, the queue and the output valid flag.
// A stalled output holds the back end only when a pull is next in the queue.
module number_base_text_converter import nbc_pkg::*; #(
  parameter int WORD_BITS       = 32,
  parameter int MAX_INPUT_CHARS = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] char_out,
  output logic       last_char,
  output logic       empty_res
);

  q_item_t q_item;
  logic    q_valid;
  logic    q_pop;

  nbc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .char_in  (char_in),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop)
  );

  nbc_back #(
    .WORD_BITS       (WORD_BITS),
    .MAX_INPUT_CHARS (MAX_INPUT_CHARS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_out  (char_out),
    .last_char (last_char),
    .empty_res (empty_res)
  );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import nbc_pkg::*;

  localparam int unsigned RUN_ITEMS = 1550;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LINE_MAX = 20;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       empty;
  } text_beat_t;

  typedef struct {
    bit         idle;
    string      text;
    logic [7:0] term;
    bit         poke;
    string      want;
  } dir_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       action = 1'b0;
  logic [7:0] char_in = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] char_out;
  logic       last_char;
  logic       empty_res;

  text_beat_t  text_due[$];
  int unsigned err_cnt = 0;
  int unsigned beats_sent = 0;
  int unsigned cyc = 0;
  bit          calm = 1'b0;

  // line state of the converter as seen from outside
  logic [31:0] m_acc;
  kind_t       m_kind;
  int unsigned m_seen;
  bit          m_pend;
  string       m_txt;
  int unsigned m_idx;

  number_base_text_converter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .char_in   (char_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_out  (char_out),
    .last_char (last_char),
    .empty_res (empty_res)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(16, 40);
  endfunction

  function automatic void clear_line();
    m_acc  = '0;
    m_kind = KIND_POS;
    m_seen = 0;
  endfunction

  function automatic void convert_line();
    logic [31:0] mag;
    logic [31:0] swp;
    string       s;
    if (m_kind == KIND_NEG) m_acc = -m_acc;
    mag = m_acc[31] ? -m_acc : m_acc;
    swp = {m_acc[7:0], m_acc[15:8], m_acc[23:16], m_acc[31:24]};
    s = {"0b", $sformatf("%0b", m_acc), "\n"};
    if (m_acc[31]) s = {s, "-"};
    s = {s, $sformatf("%0d", mag), "\n"};
    s = {s, "0x", $sformatf("%0h", m_acc), "\n"};
    s = {s, $sformatf("%0d", swp), "\n"};
    m_txt  = s;
    m_idx  = 0;
    m_pend = 1'b1;
  endfunction

  function automatic void push_char(logic [7:0] c);
    logic [31:0] dig;
    if (m_pend) return;
    if (c == CH_NL || c == CH_NUL) begin
      convert_line();
      return;
    end
    if (m_seen >= LINE_MAX) return;
    if (m_seen == 0 && c == CH_MINUS) begin
      m_kind = KIND_NEG;
    end else if (m_seen == 1 && c == CH_X) begin
      m_kind = KIND_HEX;
      m_acc  = '0;
    end else begin
      dig = (c < CH_LOWER_A) ? 32'(c) - 32'(DIGIT_OFS) : 32'(c) - 32'(ALPHA_OFS);
      m_acc = m_acc * ((m_kind == KIND_HEX) ? 32'd16 : 32'd10) + dig;
    end
    m_seen++;
  endfunction

  function automatic void conv_accept(input logic act, input logic [7:0] c,
                                      output bit has, output text_beat_t b);
    has = 1'b0;
    b   = '{8'h00, 1'b0, 1'b0};
    if (!act) begin
      push_char(c);
      return;
    end
    has = 1'b1;
    if (!m_pend) begin
      b.empty = 1'b1;
      return;
    end
    b.ch   = m_txt[m_idx];
    b.last = (m_idx == m_txt.len() - 1);
    m_idx++;
    if (b.last) begin
      m_pend = 1'b0;
      clear_line();
    end
  endfunction

  function automatic void note_err(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endfunction

  task automatic send_beat(input logic act, input logic [7:0] c,
                           input bit typed, input text_beat_t tb);
    int         g;
    bit         has;
    text_beat_t b;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    char_in  <= c;
    do @(posedge clk); while (in_stall);
    conv_accept(act, c, has, b);
    if (has) text_due.push_back(typed ? tb : b);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic pull_block(input bit poke);
    text_beat_t none;
    int         k;
    none = '{8'h00, 1'b0, 1'b0};
    k = 0;
    while (m_pend) begin
      if (poke && k == 1) begin
        send_beat(1'b0, "9", 1'b0, none);
        send_beat(1'b0, CH_NL, 1'b0, none);
      end
      if (!poke && $urandom_range(0, 19) == 0)
        send_beat(1'b0, 8'($urandom_range(0, 255)), 1'b0, none);
      else
        send_beat(1'b1, 8'($urandom_range(0, 255)), 1'b0, none);
      k++;
    end
  endtask

  dir_row_t dir_tab [16] = '{
    '{1'b1, "", CH_NL, 1'b0, ""},
    '{1'b0, "", CH_NL, 1'b0, "0b0\n0\n0x0\n0\n"},
    '{1'b0, "0xffffffff", CH_NL, 1'b0,
      "0b11111111111111111111111111111111\n-1\n0xffffffff\n4294967295\n"},
    '{1'b0, "-2147483648", CH_NL, 1'b0,
      "0b10000000000000000000000000000000\n-2147483648\n0x80000000\n128\n"},
    '{1'b0, "4294967295", CH_NL, 1'b0, ""},
    '{1'b0, "4294967296", CH_NL, 1'b0, ""},
    '{1'b0, "0x7fffffff", CH_NL, 1'b0, ""},
    '{1'b0, "123", CH_NUL, 1'b0, ""},
    '{1'b0, "0xb1ab", CH_NL, 1'b0, ""},
    '{1'b0, "-x12", CH_NL, 1'b0, ""},
    '{1'b0, "123456789012345678901234", CH_NL, 1'b0, ""},
    '{1'b0, "99999999999", CH_NUL, 1'b0, ""},
    '{1'b0, "0", CH_NL, 1'b1, ""},
    '{1'b0, "12a", CH_NL, 1'b0, ""},
    '{1'b0, "-0", CH_NL, 1'b0, ""},
    '{1'b1, "", CH_NL, 1'b0, ""}
  };

  initial begin : stim
    text_beat_t  none;
    text_beat_t  tb;
    logic [7:0]  line_q[$];
    logic [7:0]  term;
    string       hexd;
    int          r;
    int          n;
    none = '{8'h00, 1'b0, 1'b0};
    hexd = "0123456789abcdef";
    clear_line();
    m_pend = 1'b0;
    m_idx  = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].idle) begin
        send_beat(1'b1, 8'hff, 1'b1, '{8'h00, 1'b0, 1'b1});
      end else begin
        for (int k = 0; k < dir_tab[i].text.len(); k++)
          send_beat(1'b0, dir_tab[i].text[k], 1'b0, none);
        send_beat(1'b0, dir_tab[i].term, 1'b0, none);
        if (dir_tab[i].want.len() != 0) begin
          for (int k = 0; k < dir_tab[i].want.len(); k++) begin
            tb = '{dir_tab[i].want[k], k == dir_tab[i].want.len() - 1, 1'b0};
            send_beat(1'b1, 8'h00, 1'b1, tb);
          end
        end else begin
          pull_block(dir_tab[i].poke);
        end
      end
    end

    while (beats_sent < RUN_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      line_q.delete();
      r = $urandom_range(0, 99);
      if (r < 30) begin
        n = $urandom_range(1, 10);
        repeat (n) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end else if (r < 40) begin
        n = $urandom_range(11, 24);
        repeat (n) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end else if (r < 60) begin
        line_q.push_back(CH_MINUS);
        n = $urandom_range(1, 11);
        repeat (n) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end else if (r < 87) begin
        line_q.push_back((r < 82) ? CH_ZERO : CH_MINUS);
        line_q.push_back(CH_X);
        n = $urandom_range(1, 9);
        repeat (n) line_q.push_back(hexd[$urandom_range(0, 15)]);
      end else begin
        n = $urandom_range(0, 25);
        repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
      end
      term = ($urandom_range(0, 3) == 0) ? CH_NUL : CH_NL;
      foreach (line_q[k]) begin
        if ($urandom_range(0, 29) == 0)
          send_beat(1'b1, 8'($urandom_range(0, 255)), 1'b0, none);
        send_beat(1'b0, line_q[k], 1'b0, none);
      end
      send_beat(1'b0, term, 1'b0, none);
      pull_block(1'b0);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_beat(1'b1, 8'($urandom_range(0, 255)), 1'b0, none);
    end

    in_valid <= 1'b0;
    while (text_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (err_cnt == 0 && text_due.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin : out_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
        hold_left = gap_len();
      end
    end
  end

  always @(posedge clk) begin : chk
    text_beat_t w;
    if (!rst && out_valid && !out_stall) begin
      if (text_due.size() == 0) begin
        note_err($sformatf("unexpected beat %h/%b/%b", char_out, last_char, empty_res));
      end else begin
        w = text_due.pop_front();
        if (char_out !== w.ch || last_char !== w.last || empty_res !== w.empty)
          note_err($sformatf("char/last/empty exp %h/%b/%b got %h/%b/%b",
                             w.ch, w.last, w.empty, char_out, last_char, empty_res));
      end
    end
  end

  initial begin : watchdog
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= CYCLE_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

endmodule
